// ===== rtl/lfrl_pkg.sv =====
// Shared types and constants of the login flood rate limiter.
// Depends on nothing; every other file of the block but lfrl_ram imports it.
package lfrl_pkg;

  // Field widths
  localparam int unsigned UserW   = 10;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned StampW  = 16;
  localparam int unsigned TallyW  = 8;
  localparam int unsigned MinEpW  = 27;
  localparam int unsigned HourEpW = 21;
  localparam int unsigned MaxUsers = 1024;

  // APB register map (word index = paddr[4:2])
  localparam int unsigned PaddrW = 5;
  localparam logic [2:0] REG_REPEAT_WIN = 3'd0;
  localparam logic [2:0] REG_MIN_REJECT = 3'd1;
  localparam logic [2:0] REG_HOUR_REJECT = 3'd2;
  localparam logic [2:0] REG_MIN_DELAY = 3'd3;
  localparam logic [2:0] REG_HOUR_DELAY = 3'd4;

  // Register reset values
  localparam logic [StampW-1:0] RESET_REPEAT_WIN = 16'd3;
  localparam logic [TallyW-1:0] RESET_MIN_REJECT = 8'd30;
  localparam logic [TallyW-1:0] RESET_HOUR_REJECT = 8'd60;
  localparam logic [TallyW-1:0] RESET_MIN_DELAY = 8'd5;
  localparam logic [TallyW-1:0] RESET_HOUR_DELAY = 8'd20;

  // x/15 == (x * DIV15_MAGIC) >> DIV15_SHIFT for every x below 2^32
  localparam logic [31:0] DIV15_MAGIC = 32'h8888_8889;
  localparam int unsigned DIV15_SHIFT = 35;

  localparam logic [TallyW-1:0] TALLY_MAX = 8'hFF;

  typedef enum logic [1:0] {
    VERDICT_ACCEPT = 2'd0,
    VERDICT_DELAY  = 2'd1,
    VERDICT_REJECT = 2'd2
  } verdict_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HOUR,
    ST_EVAL
  } state_e;

  typedef struct packed {
    logic [StampW-1:0] repeat_win;
    logic [TallyW-1:0] min_reject;
    logic [TallyW-1:0] hour_reject;
    logic [TallyW-1:0] min_delay;
    logic [TallyW-1:0] hour_delay;
  } cfg_t;

  typedef struct packed {
    logic [StampW-1:0]  stamp;
    logic [TallyW-1:0]  min_tally;
    logic [TallyW-1:0]  hour_tally;
    logic [MinEpW-1:0]  min_epoch;
    logic [HourEpW-1:0] hour_epoch;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage

// ===== rtl/lfrl_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module lfrl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lfrl_regs.sv =====
// APB configuration registers of the rate limiter: windows and limits.
// Depends on lfrl_pkg.
module lfrl_regs
  import lfrl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output cfg_t              cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign wr_en = psel & penable & pwrite;

  // Decode writes; unknown addresses are ignored
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[4:2])
        REG_REPEAT_WIN:  cfg_d.repeat_win  = pwdata[StampW-1:0];
        REG_MIN_REJECT:  cfg_d.min_reject  = pwdata[TallyW-1:0];
        REG_HOUR_REJECT: cfg_d.hour_reject = pwdata[TallyW-1:0];
        REG_MIN_DELAY:   cfg_d.min_delay   = pwdata[TallyW-1:0];
        REG_HOUR_DELAY:  cfg_d.hour_delay  = pwdata[TallyW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.repeat_win  <= RESET_REPEAT_WIN;
      cfg_q.min_reject  <= RESET_MIN_REJECT;
      cfg_q.hour_reject <= RESET_HOUR_REJECT;
      cfg_q.min_delay   <= RESET_MIN_DELAY;
      cfg_q.hour_delay  <= RESET_HOUR_DELAY;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back
  always_comb begin
    unique case (paddr[4:2])
      REG_REPEAT_WIN:  prdata = {16'd0, cfg_q.repeat_win};
      REG_MIN_REJECT:  prdata = {24'd0, cfg_q.min_reject};
      REG_HOUR_REJECT: prdata = {24'd0, cfg_q.hour_reject};
      REG_MIN_DELAY:   prdata = {24'd0, cfg_q.min_delay};
      REG_HOUR_DELAY:  prdata = {24'd0, cfg_q.hour_delay};
      default:         prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/lfrl_epoch.sv =====
// Minute and hour epoch of a timestamp by reciprocal multiplication.
// Two registered steps: minute on load, hour from the minute register in the cycle after. Depends on lfrl_pkg.
module lfrl_epoch
  import lfrl_pkg::*;
(
  input  logic               clk_i,
  input  logic               load_i,
  input  logic [TimeW-1:0]   now_i,
  output logic [MinEpW-1:0]  minute_o,
  output logic [HourEpW-1:0] hour_o
);

  logic [MinEpW-1:0]  minute_q;
  logic [HourEpW-1:0] hour_q;
  logic [61:0]        min_prod;
  logic [56:0]        hour_prod;

  // now/60 == (now>>2)/15
  assign min_prod  = 62'(now_i[TimeW-1:2]) * 62'(DIV15_MAGIC);
  // minute/60 == (minute>>2)/15
  assign hour_prod = 57'(minute_q[MinEpW-1:2]) * 57'(DIV15_MAGIC);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      minute_q <= min_prod[DIV15_SHIFT +: MinEpW];
    end
  end

  // Follow the minute register; valid in the cycle after the minute register loads
  always_ff @(posedge clk_i) begin
    hour_q <= hour_prod[DIV15_SHIFT +: HourEpW];
  end

  assign minute_o = minute_q;
  assign hour_o   = hour_q;

endmodule

// ===== rtl/login_flood_rate_limiter_core.sv =====
// Login flood rate limiter: per-user repeat window and minute/hour tallies.
// A request is taken only in ST_IDLE; it passes ST_HOUR, then ST_EVAL, which registers
// its verdict. No new request is taken until ST_EVAL is done (table read, hour epoch multiply,
// evaluate and write back through the single entry RAM). Results cannot be stalled.
// Reset: config registers take their defaults; a clearing pass zeroes all min(USER_COUNT,1024)
// table entries while busy_o is high. Depends on lfrl_pkg and submodules.
module login_flood_rate_limiter_core
  import lfrl_pkg::*;
#(
  parameter int unsigned USER_COUNT = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [UserW-1:0]   user_id_i,
  input  logic [TimeW-1:0]   now_seconds_i,
  output logic               verdict_valid_o,
  output logic [1:0]         verdict_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PaddrW-1:0]  paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned Depth = (USER_COUNT < MaxUsers) ? USER_COUNT : MaxUsers;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

  state_e state_q, state_d;
  logic [AddrW-1:0] clr_cnt_q, clr_cnt_d;
  logic [AddrW-1:0] addr_q;
  logic [StampW-1:0] low_q;
  logic user_ok_q;
  logic accept;
  logic valid_q, valid_d;
  verdict_e verdict_q, verdict_d;

  cfg_t cfg;
  logic [MinEpW-1:0]  minute;
  logic [HourEpW-1:0] hour;

  logic mem_we;
  logic [AddrW-1:0] mem_waddr;
  entry_t mem_wdata, rd_entry, upd_entry;

  logic [TallyW-1:0] mcount, hcount, mnext, hnext;
  logic [StampW-1:0] gap;
  logic reject;

  assign pready = 1'b1;
  assign accept = start_i & ~busy_o;
  assign busy_o = (state_q != ST_IDLE);

  lfrl_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  lfrl_epoch u_epoch (
    .clk_i    (clk_i),
    .load_i   (accept),
    .now_i    (now_seconds_i),
    .minute_o (minute),
    .hour_o   (hour)
  );

  lfrl_ram #(
    .WIDTH (EntryW),
    .DEPTH (Depth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (accept),
    .raddr_i (user_id_i[AddrW-1:0]),
    .rdata_o (rd_entry)
  );

  // Capture request payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q    <= user_id_i[AddrW-1:0];
      low_q     <= now_seconds_i[StampW-1:0];
      user_ok_q <= (32'(user_id_i) < 32'(USER_COUNT));
    end
  end

  // Evaluate the fetched entry against the current epochs
  always_comb begin
    mcount = (rd_entry.min_epoch == minute) ? rd_entry.min_tally : '0;
    hcount = (rd_entry.hour_epoch == hour) ? rd_entry.hour_tally : '0;
    gap    = (rd_entry.stamp >= low_q) ? (rd_entry.stamp - low_q) : (low_q - rd_entry.stamp);
    reject = ~user_ok_q || (gap <= cfg.repeat_win) ||
             (mcount > cfg.min_reject) || (hcount > cfg.hour_reject);
    mnext  = (mcount == TALLY_MAX) ? TALLY_MAX : mcount + 8'd1;
    hnext  = (hcount == TALLY_MAX) ? TALLY_MAX : hcount + 8'd1;
    upd_entry.stamp      = low_q;
    upd_entry.min_tally  = mnext;
    upd_entry.hour_tally = hnext;
    upd_entry.min_epoch  = minute;
    upd_entry.hour_epoch = hour;
  end

  // Sequencer: clear pass, then fetch / hour epoch / evaluate per request
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    valid_d   = 1'b0;
    verdict_d = verdict_q;
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = upd_entry;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
        clr_cnt_d = clr_cnt_q + AddrW'(1);
        if (clr_cnt_q == LastAddr) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_HOUR;
        end
      end
      ST_HOUR: begin
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        valid_d = 1'b1;
        state_d = ST_IDLE;
        if (reject) begin
          verdict_d = VERDICT_REJECT;
        end else begin
          mem_we = 1'b1;
          if ((mnext > cfg.min_delay) || (hnext > cfg.hour_delay)) begin
            verdict_d = VERDICT_DELAY;
          end else begin
            verdict_d = VERDICT_ACCEPT;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      valid_q   <= valid_d;
    end
  end

  // Hold verdict payload
  always_ff @(posedge clk_i) begin
    verdict_q <= verdict_d;
  end

  assign verdict_valid_o = valid_q;
  assign verdict_o       = verdict_q;

  // Table writes happen only in the clearing pass or on evaluation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_CLEAR) || (state_q == ST_EVAL))
    else $error("table write outside clear or evaluate");

  // Every evaluate cycle is followed by a verdict strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL) |=> verdict_valid_o)
    else $error("evaluate without verdict strobe");

  // A non-reject verdict always comes with a table update
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (verdict_valid_o && (verdict_o != VERDICT_REJECT)) |-> $past(mem_we))
    else $error("accept or delay without table update");

  // No request is taken while the table is being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |=> !verdict_valid_o)
    else $error("verdict during clearing pass");

endmodule
